FILE: rtl/pcbd_pkg.sv
// Package for the prefix code bit decoder: sizes, item and result beats,
// command queue entry, table entry and state types. No dependencies.
package pcbd_pkg;

  localparam int NUM_SYMBOLS    = 256;
  localparam int MAX_CODE_LEN   = 32;
  localparam int SYM_IDX_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int ACC_LEN_W      = $clog2(MAX_CODE_LEN + 1);
  localparam int CODE_W         = 32;
  localparam int LEN_W          = 6;
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        entry_symbol;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic              code_bit;
  } item_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic       overflow_error;
  } result_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DECODE,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [SYM_IDX_W-1:0] sym;
    logic [CODE_W-1:0]    code;
    logic [LEN_W-1:0]     len;
    logic                 code_bit;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  // Keeps code bits below len; len of 32 or more keeps all.
  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

endpackage

FILE: rtl/pcbd_front.sv
// Front end: classifies input beats into queue commands, drops no-op beats.
// Depends on pcbd_pkg.
module pcbd_front
  import pcbd_pkg::*;
(
  input  logic  push,
  input  item_t item,
  input  logic  fifo_full,
  output logic  full,
  output logic  cmd_push,
  output cmd_t  cmd
);

  logic keep;
  logic sym_ok;

  assign sym_ok = ({1'b0, item.entry_symbol} < 9'(NUM_SYMBOLS));

  always_comb begin
    keep         = 1'b0;
    cmd.kind     = CMD_DECODE;
    cmd.sym      = item.entry_symbol[SYM_IDX_W-1:0];
    cmd.code     = item.entry_code & code_mask(item.entry_length);
    cmd.len      = item.entry_length;
    cmd.code_bit = item.code_bit;
    unique case (item.opcode)
      OP_LOAD: begin
        keep     = sym_ok;
        cmd.kind = CMD_LOAD;
      end
      OP_DECODE: begin
        keep     = 1'b1;
        cmd.kind = CMD_DECODE;
      end
      OP_CLEAR: begin
        keep     = 1'b1;
        cmd.kind = CMD_CLEAR;
      end
      default: begin
        keep     = 1'b0;
        cmd.kind = CMD_DECODE;
      end
    endcase
  end

  assign full     = fifo_full;
  assign cmd_push = push && !fifo_full && keep;

endmodule

FILE: rtl/pcbd_cmd_fifo.sv
// Short command queue between front end and decode engine.
// Depends on pcbd_pkg.
module pcbd_cmd_fifo
  import pcbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t                 slots [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == CMD_CNT_W'(CMD_FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_cmd;
  end

endmodule

FILE: rtl/pcbd_back.sv
// Decode engine: code table memory, valid bits, accumulator, table scan
// and result register. Depends on pcbd_pkg.
module pcbd_back
  import pcbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  back_state_t          state;
  back_state_t          state_next;
  logic [SYM_IDX_W-1:0] scan_idx;
  logic [CODE_W-1:0]    acc_bits;
  logic [ACC_LEN_W-1:0] acc_len;
  logic [NUM_SYMBOLS-1:0] entry_valid;
  logic                 res_valid;
  result_t              res;

  entry_t               mem [NUM_SYMBOLS];
  entry_t               rd_q;
  logic [SYM_IDX_W-1:0] rd_addr;

  logic hit, last, ovf, out_free;
  logic do_load, do_clear, do_decode, scan_step, emit, done;
  result_t emit_res;

  assign hit = entry_valid[scan_idx] && (32'(rd_q.len) == 32'(acc_len)) &&
               (rd_q.bits == acc_bits);
  assign last     = (scan_idx == SYM_IDX_W'(NUM_SYMBOLS - 1));
  assign ovf      = (32'(acc_len) >= 32'(MAX_CODE_LEN));
  assign out_free = !res_valid || pop;

  // control outputs
  always_comb begin
    cmd_pop   = 1'b0;
    do_load   = 1'b0;
    do_clear  = 1'b0;
    do_decode = 1'b0;
    scan_step = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    emit_res  = '0;
    rd_addr   = scan_idx;
    unique case (state)
      ST_IDLE: begin
        rd_addr = '0;
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LOAD:   do_load   = 1'b1;
            CMD_DECODE: do_decode = 1'b1;
            CMD_CLEAR:  do_clear  = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          emit_res.decoded_symbol = 8'(scan_idx);
          emit = out_free;
          done = out_free;
        end else if (last) begin
          if (ovf) begin
            emit_res.overflow_error = 1'b1;
            emit = out_free;
            done = out_free;
          end else begin
            done = 1'b1;
          end
        end else begin
          scan_step = 1'b1;
          rd_addr   = scan_idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (do_decode) state_next = ST_SCAN;
      ST_SCAN: if (done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_idx    <= '0;
      acc_bits    <= '0;
      acc_len     <= '0;
      entry_valid <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_decode)      scan_idx <= '0;
      else if (scan_step) scan_idx <= scan_idx + 1'b1;

      if (do_clear || emit) begin
        acc_bits <= '0;
        acc_len  <= '0;
      end else if (do_decode) begin
        acc_bits <= {acc_bits[CODE_W-2:0], cmd.code_bit};
        acc_len  <= acc_len + 1'b1;
      end

      if (do_clear)     entry_valid <= '0;
      else if (do_load) entry_valid[cmd.sym] <= 1'b1;

      if (emit)     res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= emit_res;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_load) mem[cmd.sym] <= '{len: cmd.len, bits: cmd.code};
    rd_q <= mem[rd_addr];
  end

  assign result = res;
  assign empty  = !res_valid;

  a_acc_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(acc_len) <= 32'(MAX_CODE_LEN))
    else $error("accumulator length above maximum");

  a_emit_clears_acc: assert property (@(posedge clk) disable iff (rst)
    emit |=> (acc_len == '0) && (acc_bits == '0))
    else $error("accumulator not cleared after result");

  a_decode_starts_scan: assert property (@(posedge clk) disable iff (rst)
    do_decode |=> (state == ST_SCAN) && (scan_idx == '0) && (acc_len != '0))
    else $error("decode did not start a scan at entry zero");

  a_no_pop_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !cmd_pop)
    else $error("command taken during table scan");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |-> !emit)
    else $error("result overwritten before it was taken");

endmodule

FILE: rtl/prefix_code_bit_decoder.sv
// A beat reaches the engine through the registered command queue. The engine
// does a load or clear as it pops the command. A decode bit scans the table one
// entry per cycle (memory read port), upward from symbol zero; a match holds the
// scan until the result register is free, and a bit with no result scans it all.
// Reset (rst, synchronous) empties queue and result, clears valid bits and the
// accumulator; table memory contents are left as they are.
module prefix_code_bit_decoder
  import pcbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  // input beats: accepted when push && !full
  input  logic    push,
  input  item_t   item,
  output logic    full,
  // result beats: accepted when pop && !empty
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  // front end -> command queue
  logic cmd_push;
  cmd_t cmd_in;
  logic fifo_full;

  // command queue -> engine
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  // Front end: drops unused opcodes and out-of-range loads, masks load codes.
  pcbd_front u_front (
    .push      (push),
    .item      (item),
    .fifo_full (fifo_full),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // Queue decouples input beats from the multi-cycle table scan.
  pcbd_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .wr_cmd (cmd_in),
    .full   (fifo_full),
    .pop    (cmd_pop),
    .rd_cmd (cmd_head),
    .empty  (cmd_empty)
  );

  // Engine: lowest matching symbol wins since the scan runs upward from zero;
  // a match on the last allowed bit beats overflow. Result register parts
  // the engine from the output side.
  pcbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench for prefix_code_bit_decoder: random prefix code
// tables and bit streams, predicted in-line and compared on every result beat.
// Depends on pcbd_pkg (item_t, result_t, opcodes, sizes) and the decoder RTL.
module tb;
  import pcbd_pkg::*;

  // Opcode 3 has no meaning in the block; it must be dropped silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TARGET_BEATS = 1200;
  // A no-result bit scans the whole table and up to four more can sit in
  // the command queue, so the tail wait covers all of them.
  localparam int TAIL_CYCLES = 2000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  prefix_code_bit_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder shadow: code table, bit accumulator, queue of due results
  // ---------------------------------------------------------------------
  logic              tbl_valid [NUM_SYMBOLS];
  logic [LEN_W-1:0]  tbl_len   [NUM_SYMBOLS];
  logic [CODE_W-1:0] tbl_bits  [NUM_SYMBOLS];
  logic [CODE_W-1:0] acc_bits;
  int                acc_cnt;
  result_t           symbols_due[$];

  item_t   pending[$];     // beats still to be offered to the block
  int      useful_beats;   // beats that the block does not just drop
  int      total_beats;
  int      beats_in;       // beats accepted so far
  int      errors;
  logic    took_item = 1'b0;
  result_t want;

  // Mask for the low n code bits; n at or above the code width keeps all.
  function automatic logic [CODE_W-1:0] keep_mask(int n);
    return (n >= CODE_W) ? '1 : ((CODE_W'(1) << n) - CODE_W'(1));
  endfunction

  task automatic clear_acc();
    acc_bits = '0;
    acc_cnt  = 0;
  endtask

  // Applies one accepted beat to the shadow and queues any result it causes.
  task automatic predict_symbol(input item_t it);
    int      hit;
    result_t r;
    case (it.opcode)
      OP_LOAD: begin
        if (int'(it.entry_symbol) < NUM_SYMBOLS) begin
          tbl_valid[it.entry_symbol] = 1'b1;
          tbl_len[it.entry_symbol]   = it.entry_length;
          tbl_bits[it.entry_symbol]  = it.entry_code & keep_mask(int'(it.entry_length));
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_SYMBOLS; i++) tbl_valid[i] = 1'b0;
        clear_acc();
      end
      OP_DECODE: begin
        acc_bits = {acc_bits[CODE_W-2:0], it.code_bit};
        acc_cnt++;
        hit = -1;
        // lowest symbol wins when several entries hold the same code
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
          if (hit < 0 && tbl_valid[i] && int'(tbl_len[i]) == acc_cnt &&
              tbl_bits[i] == (acc_bits & keep_mask(acc_cnt))) begin
            hit = i;
          end
        end
        // a match on the last allowed bit beats the overflow
        if (hit >= 0) begin
          r.decoded_symbol = 8'(hit);
          r.overflow_error = 1'b0;
          symbols_due.push_back(r);
          clear_acc();
        end else if (acc_cnt >= MAX_CODE_LEN) begin
          r.decoded_symbol = 8'd0;
          r.overflow_error = 1'b1;
          symbols_due.push_back(r);
          clear_acc();
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  task automatic queue_beat(input logic [1:0] op, input logic [7:0] sym,
                            input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len, input logic b);
    item_t it;
    it.opcode       = op;
    it.entry_symbol = sym;
    it.entry_code   = code;
    it.entry_length = len;
    it.code_bit     = b;
    pending.push_back(it);
    if (op != OP_UNUSED) useful_beats++;
  endtask

  task automatic queue_bit(input logic b);
    queue_beat(OP_DECODE, 8'($urandom), $urandom, 6'($urandom), b);
  endtask

  // One session: build a random prefix code by splitting leaves, load it,
  // then stream codewords. Some sessions leave a leaf unloaded (its bits then
  // run into overflow), add a duplicate code, or load a dead entry.
  task automatic queue_session();
    logic [CODE_W-1:0] codes[$];
    int                lens[$];
    int                syms[$];
    bit                used[256];
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] ld;
    bit                skew;
    int                n, cap, idx, tries, drop, k, s, roll;
    if ($urandom_range(0, 1) == 1) queue_beat(OP_CLEAR, 8'($urandom), $urandom, 6'($urandom), 1'($urandom));
    // skewed trees always split the newest leaf and reach a code length of 23 to 32 bits
    skew = ($urandom_range(0, 7) == 0);
    n    = skew ? $urandom_range(24, 33) : $urandom_range(2, 24);
    cap  = skew ? MAX_CODE_LEN : 12;
    codes.push_back('0);
    lens.push_back(1);
    codes.push_back(CODE_W'(1));
    lens.push_back(1);
    tries = 0;
    while (codes.size() < n && tries < 500) begin
      tries++;
      idx = skew ? codes.size() - 1 : $urandom_range(0, codes.size() - 1);
      if (lens[idx] < cap) begin
        c = codes[idx];
        codes[idx] = {c[CODE_W-2:0], 1'b0};
        lens[idx]++;
        codes.push_back({c[CODE_W-2:0], 1'b1});
        lens.push_back(lens[idx]);
      end
    end
    for (int i = 0; i < 256; i++) used[i] = 1'b0;
    for (int i = 0; i < codes.size(); i++) begin
      do s = $urandom_range(0, 255); while (used[s]);
      used[s] = 1'b1;
      syms.push_back(s);
    end
    drop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, codes.size() - 1) : -1;
    for (int i = 0; i < codes.size(); i++) begin
      // garbage above the code length must be dropped by the block
      ld = (lens[i] >= CODE_W) ? codes[i] : (codes[i] | ($urandom << lens[i]));
      if (i != drop) queue_beat(OP_LOAD, 8'(syms[i]), ld, 6'(lens[i]), 1'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, codes.size() - 1);
      do s = $urandom_range(0, 255); while (used[s]);
      used[s] = 1'b1;
      queue_beat(OP_LOAD, 8'(s), codes[k], 6'(lens[k]), 1'($urandom));
    end
    // dead entries: zero length, or longer than the accumulator can get
    if ($urandom_range(0, 3) == 0) begin
      queue_beat(OP_LOAD, 8'($urandom), $urandom,
                 ($urandom_range(0, 1) == 1) ? 6'd0 : 6'($urandom_range(33, 63)), 1'($urandom));
    end
    repeat ($urandom_range(5, 30)) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        k = $urandom_range(0, codes.size() - 1);
        for (int b = lens[k] - 1; b >= 0; b--) queue_bit(codes[k][b]);
      end else if (roll < 95) begin
        repeat ($urandom_range(1, 8)) queue_bit(1'($urandom));
      end else begin
        queue_beat(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom), 1'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    took_item = 1'b0;
    if (rst) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) tbl_valid[i] = 1'b0;
      clear_acc();
    end else begin
      if (push && !full) begin
        took_item = 1'b1;
        predict_symbol(item);
        pending.delete(0);
        beats_in++;
      end
      if (pop && !empty) begin
        if (symbols_due.size() == 0) begin
          $display("%0t: unexpected result beat sym %0d ovf %0b", $time,
                   result.decoded_symbol, result.overflow_error);
          errors++;
        end else begin
          want = symbols_due.pop_front();
          if (result.decoded_symbol != want.decoded_symbol) begin
            $display("%0t: decoded_symbol expected %0d got %0d", $time,
                     want.decoded_symbol, result.decoded_symbol);
            errors++;
          end
          if (result.overflow_error != want.overflow_error) begin
            $display("%0t: overflow_error expected %0b got %0b", $time,
                     want.overflow_error, result.overflow_error);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: changes inputs at the falling edge
  // Phases by progress: no idling, sender idle, receiver stall, both.
  // At each phase change the sender holds off until all results are back.
  // ---------------------------------------------------------------------
  int   phase = 0;
  int   phase_now;
  logic drain_wait = 1'b0;
  logic go;

  function automatic int idle_pct(int ph, bit sender);
    case (ph)
      1:       return sender ? 54 : 0;
      2:       return sender ? 0 : 54;
      3:       return 16;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      // a beat on offer stays put until the block takes it
      if (!push || took_item) begin
        phase_now = (beats_in * 4) / total_beats;
        if (phase_now > 3) phase_now = 3;
        if (phase_now != phase) begin
          phase      = phase_now;
          drain_wait = 1'b1;
        end
        if (drain_wait && symbols_due.size() == 0) drain_wait = 1'b0;
        go = (pending.size() != 0) && !drain_wait &&
             ($urandom_range(0, 99) >= idle_pct(phase, 1'b1));
        push <= go;
        if (go) item <= pending[0];
      end
      pop <= ($urandom_range(0, 99) >= idle_pct(phase, 1'b0));
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed beats, random sessions, reset, drain, verdict
  // ---------------------------------------------------------------------
  initial begin
    useful_beats = 0;
    beats_in     = 0;
    errors       = 0;

    // bit against an empty table, then a dropped opcode with all ones
    queue_bit(1'b1);
    queue_beat(OP_UNUSED, '1, '1, '1, 1'b1);
    // table extremes: all-ones full-length code, code bits above the length,
    // zero length, length past the code width, duplicate of symbol 0
    queue_beat(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
    queue_beat(OP_LOAD, 8'd0, 32'hFFFF_FFFE, 6'd1, 1'b0);
    queue_beat(OP_LOAD, 8'd200, 32'h0000_0000, 6'd0, 1'b0);
    queue_beat(OP_LOAD, 8'd9, 32'h5555_5555, 6'd63, 1'b1);
    queue_beat(OP_LOAD, 8'd3, 32'h0000_0000, 6'd1, 1'b0);
    queue_beat(OP_LOAD, 8'd128, 32'h0000_0002, 6'd2, 1'b0);
    queue_bit(1'b0);   // leftover 1 then 0 -> symbol 128
    queue_bit(1'b0);   // symbol 0 wins over symbol 3
    queue_beat(OP_CLEAR, '0, '0, '0, 1'b0);
    queue_beat(OP_LOAD, 8'd1, 32'h0000_0001, 6'd1, 1'b0);
    queue_bit(1'b1);   // symbol 1
    queue_bit(1'b0);   // no match, left in the accumulator
    queue_beat(OP_CLEAR, '1, '1, '1, 1'b1);
    // full-length code matches on the last bit; then 32 misses overflow
    queue_beat(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 1'b1);
    repeat (MAX_CODE_LEN) queue_bit(1'b1);
    repeat (MAX_CODE_LEN) queue_bit(1'b0);

    while (useful_beats < TARGET_BEATS) queue_session();
    total_beats = pending.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pcbd_pkg.sv
rtl/pcbd_front.sv
rtl/pcbd_cmd_fifo.sv
rtl/pcbd_back.sv
rtl/prefix_code_bit_decoder.sv
test/tb.sv
